// ===== sv/cab_buffer_manager_top_macros.svh =====
// Assertion macros used by the checker file of the buffer manager.
`ifndef CAB_BUFFER_MANAGER_TOP_MACROS_SVH
`define CAB_BUFFER_MANAGER_TOP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define CAB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define CAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cab_pkg.sv =====
// Types and constants of the cyclic asynchronous buffer index manager.
package cab_pkg;

   localparam int MAX_BUFFERS_DEFAULT = 8;
   localparam int MIN_BUFFERS         = 2;
   localparam int RESET_BUFFERS       = 8;
   localparam int CSR_W               = 4;
   localparam int IDX_W               = 3;
   localparam int COUNT_W             = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_RESERVE = 2'd0,
      CMD_PUT     = 2'd1,
      CMD_GET     = 2'd2,
      CMD_RELEASE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_COUNT_ERR = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [IDX_W-1:0] buffer_index;
   } request_type;

   typedef struct packed {
      logic [IDX_W-1:0] result_index;
      logic [1:0]       status;
   } response_type;

   typedef enum logic {
      CTRL_EMPTY,
      CTRL_FULL
   } ctrl_state_type;

   typedef struct packed {
      logic execute;
   } ctrl_cmd_type;

endpackage

// ===== sv/cab_controller.sv =====
// Handshake controller: tracks whether the response register holds a transaction.
module cab_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cab_pkg::ctrl_cmd_type cmd
);

   cab_pkg::ctrl_state_type state_ff;
   cab_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cab_pkg::CTRL_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      rsp_valid   = 1'b0;
      req_stall   = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         cab_pkg::CTRL_EMPTY: begin
            cmd.execute = req_valid;
            if (req_valid) begin
               state_in = cab_pkg::CTRL_FULL;
            end
         end
         cab_pkg::CTRL_FULL: begin
            rsp_valid = 1'b1;
            // A new transaction may replace the response only as it leaves.
            req_stall   = rsp_stall;
            cmd.execute = req_valid && !rsp_stall;
            if (!rsp_stall && !req_valid) begin
               state_in = cab_pkg::CTRL_EMPTY;
            end
         end
         default: begin
            state_in = cab_pkg::CTRL_EMPTY;
         end
      endcase
   end

endmodule

// ===== sv/cab_datapath.sv =====
// Datapath: free list, newest buffer, reader counts and the response register.
module cab_datapath #(
   parameter int MAX_BUFFERS = cab_pkg::MAX_BUFFERS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [cab_pkg::CSR_W-1:0]  csr_write_data,
   input  cab_pkg::ctrl_cmd_type      cmd,
   input  cab_pkg::request_type       req_payload,
   output cab_pkg::response_type      rsp_payload
);

   localparam int AW = $clog2(MAX_BUFFERS);
   localparam int HW = $clog2(MAX_BUFFERS + 1);
   localparam int XW = (HW > cab_pkg::CSR_W) ? HW : cab_pkg::CSR_W;

   logic [HW-1:0]               count_ff;
   logic [HW-1:0]               head_ff;
   logic [AW-1:0]               newest_ff;
   logic [HW-1:0]               links_ff  [MAX_BUFFERS];
   logic [cab_pkg::COUNT_W-1:0] counts_ff [MAX_BUFFERS];
   cab_pkg::response_type       result_ff;

   logic [XW-1:0]               init_raw;
   logic [HW-1:0]               init_n;
   logic [HW-1:0]               init_links [MAX_BUFFERS];

   logic [XW-1:0]               idx_x;
   logic [AW-1:0]               idx_a;
   logic                        idx_ok;
   logic [AW-1:0]               cnt_addr;
   logic [cab_pkg::COUNT_W-1:0] cnt_rd;
   logic [cab_pkg::COUNT_W-1:0] cnt_dec;

   logic [HW-1:0]               head_in;
   logic [AW-1:0]               newest_in;
   logic                        link_we;
   logic [AW-1:0]               link_addr;
   logic                        cnt_we;
   logic [cab_pkg::COUNT_W-1:0] cnt_data;
   cab_pkg::response_type       result_in;
   cab_pkg::status_type         st;

   // Pool size after reset or a register write, saturated to the legal range.
   always_comb begin
      init_raw = reset ? XW'(cab_pkg::RESET_BUFFERS) : XW'(csr_write_data);
      if (init_raw < XW'(cab_pkg::MIN_BUFFERS)) begin
         init_n = HW'(cab_pkg::MIN_BUFFERS);
      end else if (init_raw > XW'(MAX_BUFFERS)) begin
         init_n = HW'(MAX_BUFFERS);
      end else begin
         init_n = HW'(init_raw);
      end
      // The last buffer starts as the newest, so the list stops one short of it.
      for (int i = 0; i < MAX_BUFFERS; i++) begin
         init_links[i] = (i + 1 < int'(init_n) - 1) ? HW'(i + 1) : HW'(MAX_BUFFERS);
      end
   end

   assign idx_x    = XW'(req_payload.buffer_index);
   assign idx_a    = AW'(req_payload.buffer_index);
   assign idx_ok   = idx_x < XW'(count_ff);
   assign cnt_addr = (req_payload.command == cab_pkg::CMD_RELEASE) ? idx_a : newest_ff;
   assign cnt_rd   = counts_ff[cnt_addr];
   assign cnt_dec  = cnt_rd - cab_pkg::COUNT_W'(1);

   always_comb begin
      head_in   = head_ff;
      newest_in = newest_ff;
      link_we   = 1'b0;
      link_addr = newest_ff;
      cnt_we    = 1'b0;
      cnt_data  = cnt_rd;
      st        = cab_pkg::STATUS_OK;
      result_in.result_index = req_payload.buffer_index;
      case (req_payload.command)
         cab_pkg::CMD_RESERVE: begin
            if (head_ff >= count_ff) begin
               st = cab_pkg::STATUS_EMPTY;
               result_in.result_index = '0;
            end else begin
               result_in.result_index = cab_pkg::IDX_W'(head_ff);
               head_in = links_ff[head_ff[AW-1:0]];
            end
         end
         cab_pkg::CMD_PUT: begin
            if (!idx_ok) begin
               st = cab_pkg::STATUS_COUNT_ERR;
            end else begin
               // The old newest goes back to the pool unless a reader holds it or it is put again.
               if (cnt_rd == '0 && newest_ff != idx_a) begin
                  link_we   = 1'b1;
                  link_addr = newest_ff;
                  head_in   = HW'(newest_ff);
               end
               newest_in = idx_a;
            end
         end
         cab_pkg::CMD_GET: begin
            result_in.result_index = cab_pkg::IDX_W'(newest_ff);
            if (cnt_rd == cab_pkg::COUNT_MAX) begin
               st = cab_pkg::STATUS_COUNT_ERR;
            end else begin
               cnt_we   = 1'b1;
               cnt_data = cnt_rd + cab_pkg::COUNT_W'(1);
            end
         end
         cab_pkg::CMD_RELEASE: begin
            if (!idx_ok || cnt_rd == '0) begin
               st = cab_pkg::STATUS_COUNT_ERR;
            end else begin
               cnt_we   = 1'b1;
               cnt_data = cnt_dec;
               if (cnt_dec == '0 && idx_a != newest_ff) begin
                  link_we   = 1'b1;
                  link_addr = idx_a;
                  head_in   = HW'(idx_a);
               end
            end
         end
         default: begin
            st = cab_pkg::STATUS_OK;
         end
      endcase
      result_in.status = st;
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         count_ff  <= init_n;
         head_ff   <= '0;
         newest_ff <= AW'(init_n - HW'(1));
         links_ff  <= init_links;
         counts_ff <= '{default: '0};
      end else if (cmd.execute) begin
         head_ff   <= head_in;
         newest_ff <= newest_in;
         if (link_we) begin
            links_ff[link_addr] <= head_ff;
         end
         if (cnt_we) begin
            counts_ff[cnt_addr] <= cnt_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         result_ff <= result_in;
      end
   end

   assign rsp_payload = result_ff;

endmodule

// ===== sv/cab_buffer_manager_top.sv =====
// Index manager of a cyclic asynchronous buffer: one writer, several readers.
//
// Request channel (req_valid, req_stall, req_payload) carries a command and a
// buffer index: reserve pops the free list, put publishes a buffer as the
// newest, get hands out the newest buffer and counts a reader, release drops
// a reader and returns the buffer to the pool once unused and not newest.
// Response channel (rsp_valid, rsp_stall, rsp_payload) returns one transaction
// per request with the buffer index and a status code.
// A request that is taken shows its response from the next cycle on.
// Throughput is one transaction per cycle while rsp_stall is low, set by the
// single response register; the tables are flip-flop arrays written with it.
// While the receiver stalls a waiting response, req_stall follows rsp_stall
// and the response holds; a new request is taken in the cycle it leaves.
// Synchronous reset builds a pool of eight buffers (capped at MAX_BUFFERS) and
// empties the response register. A write on csr_write_enable rebuilds the pool
// with the written size, saturated to 2..MAX_BUFFERS, in the same cycle.
module cab_buffer_manager_top #(
   parameter int MAX_BUFFERS = cab_pkg::MAX_BUFFERS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cab_pkg::request_type      req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cab_pkg::response_type     rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [cab_pkg::CSR_W-1:0] csr_write_data
);

   cab_pkg::ctrl_cmd_type cmd;

   cab_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cab_datapath #(
      .MAX_BUFFERS (MAX_BUFFERS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .req_payload      (req_payload),
      .rsp_payload      (rsp_payload)
   );

endmodule

// ===== sv/cab_checker.sv =====
// Port-level checker for the buffer manager and its bind to the top level.
`include "cab_buffer_manager_top_macros.svh"

module cab_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input cab_pkg::response_type rsp_payload
);

   // A stalled response stays and does not change.
   `CAB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled response changed")

   // Every accepted transaction produces a response in the next cycle.
   `CAB_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && !req_stall, rsp_valid, "no response after request")

   // The block never stalls requests while its response register is empty.
   `CAB_ASSERT_NOW(a_empty_ready, clock, reset, !rsp_valid, !req_stall, "stall with empty output")

   // A held response blocks new requests.
   `CAB_ASSERT_NOW(a_full_stall, clock, reset, rsp_valid && rsp_stall, req_stall, "request taken while output held")

   // Reset leaves no response pending.
   `CAB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response pending after reset")

endmodule

bind cab_buffer_manager_top cab_checker u_checker (.*);
